@@ rtl/isrm_pkg.sv @@
// ----------------------------------------------------------------------------
// isrm_pkg
// Shared types and constants for the integer stack with remove.
// ----------------------------------------------------------------------------
package isrm_pkg;

  // Default sizing
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned WORD_BITS_DEF   = 32;

  // Fixed field widths on the stream ports
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned DEPTH_W  = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Shift controls broadcast to every cell, already qualified
  typedef struct packed {
    logic push;    // every cell takes its upper neighbor
    logic pop;     // every cell takes its lower neighbor
    logic remove;  // cells at or below the topmost match take lower neighbor
  } cell_ctl_t;

endpackage

@@ rtl/isrm_cell.sv @@
// ----------------------------------------------------------------------------
// isrm_cell
// One stack slot: holds a word, compares it against the remove key and
// passes the "match at or above" flag down the chain.
// ----------------------------------------------------------------------------
module isrm_cell #(
  parameter int unsigned WORD_BITS = isrm_pkg::WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  isrm_pkg::cell_ctl_t  ctl_i,
  input  logic                 valid_i,      // slot holds a live entry
  input  logic [WORD_BITS-1:0] key_i,        // remove key
  input  logic [WORD_BITS-1:0] upper_i,      // neighbor toward top
  input  logic [WORD_BITS-1:0] lower_i,      // neighbor toward bottom
  input  logic                 hit_above_i,  // match found in a higher slot
  output logic                 hit_below_o,  // match here or above
  output logic [WORD_BITS-1:0] word_o
);

  logic [WORD_BITS-1:0] word_q, word_d;
  logic                 hit_here;

  assign hit_here    = valid_i && (word_q == key_i);
  assign hit_below_o = hit_above_i || hit_here;

  always_comb begin
    word_d = word_q;
    if (ctl_i.push) begin
      word_d = upper_i;
    end else if (ctl_i.pop || (ctl_i.remove && hit_below_o)) begin
      word_d = lower_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

@@ rtl/integer_stack_with_remove.sv @@
// ----------------------------------------------------------------------------
// integer_stack_with_remove
// Bounded LIFO of signed words with push, pop, peek at depth and
// remove-by-value, built as a row of shifting slot cells.
// ----------------------------------------------------------------------------
//
//  channel | dir | signals                  | contents
//  --------+-----+--------------------------+-------------------------------
//  s_axis  | in  | tvalid/tready/tdata/tuser| command request
//  m_axis  | out | tvalid/tready/tdata      | one result per request
//
//  Cycles: one request per cycle while m_axis does not back-pressure.
//  The cell row and the output register both update on the accepting edge.
//  The input is ready whenever the output register is empty or being
//  drained, so back-pressure on m_axis stalls s_axis directly.
//  Reset clears the fill count and output valid; slot contents are not
//  reset, and only slots below the fill count are ever read.
//
// Slot 0 is the top of stack. Push shifts every slot down one place,
// pop shifts every slot up. Remove ripples a match flag from the top:
// every slot at or below the topmost match takes its lower neighbor,
// which closes the gap and keeps the order of the rest.
module integer_stack_with_remove #(
  parameter int unsigned STACK_DEPTH = isrm_pkg::STACK_DEPTH_DEF,
  parameter int unsigned WORD_BITS   = isrm_pkg::WORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command request
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] value, [36:32] depth_pos, [39:37] zero
  input  logic [isrm_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [isrm_pkg::CMD_W-1:0]     s_axis_tuser,
  // result
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] data, [33:32] status, [38:34] count, [39] is_empty
  output logic [isrm_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic                                 req_fire;
  isrm_pkg::cmd_e                       cmd;
  logic signed [isrm_pkg::VALUE_W-1:0]  value;
  logic [isrm_pkg::DEPTH_W-1:0]         depth_pos;
  logic signed [63:0]                   value_ext;
  logic [WORD_BITS-1:0]                 word_in;

  assign cmd       = isrm_pkg::cmd_e'(s_axis_tuser);
  assign value     = s_axis_tdata[isrm_pkg::VALUE_W-1:0];
  assign depth_pos = s_axis_tdata[isrm_pkg::VALUE_W +: isrm_pkg::DEPTH_W];
  // word taken from the low bits, sign-extended when the word is wider
  assign value_ext = 64'(value);
  assign word_in   = value_ext[WORD_BITS-1:0];

  // --------------------------------------------------------------------------
  // Fill count and cell row
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 is_empty_now, is_full_now;
  isrm_pkg::cell_ctl_t  ctl;
  logic [WORD_BITS-1:0] cell_word [STACK_DEPTH];
  logic [STACK_DEPTH:0] hit_chain;
  logic                 found;

  assign is_empty_now = (count_q == '0);
  assign is_full_now  = (32'(count_q) >= STACK_DEPTH);

  assign hit_chain[0] = 1'b0;
  assign found        = hit_chain[STACK_DEPTH];

  always_comb begin
    ctl        = '0;
    ctl.push   = req_fire && (cmd == isrm_pkg::CMD_PUSH)   && !is_full_now;
    ctl.pop    = req_fire && (cmd == isrm_pkg::CMD_POP)    && !is_empty_now;
    // no match leaves the whole hit chain low, so nothing shifts
    ctl.remove = req_fire && (cmd == isrm_pkg::CMD_REMOVE);
  end

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] upper, lower;
    logic                 live;

    if (g == 0) begin : g_top
      assign upper = word_in;
    end else begin : g_mid
      assign upper = cell_word[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_bot
      assign lower = '0;
    end else begin : g_up
      assign lower = cell_word[g+1];
    end
    assign live = (32'(g) < 32'(count_q));

    isrm_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .valid_i     (live),
      .key_i       (word_in),
      .upper_i     (upper),
      .lower_i     (lower),
      .hit_above_i (hit_chain[g]),
      .hit_below_o (hit_chain[g+1]),
      .word_o      (cell_word[g])
    );
  end

  // --------------------------------------------------------------------------
  // Peek select and result
  // --------------------------------------------------------------------------
  logic [isrm_pkg::DEPTH_W-1:0]          depth_eff, peek_idx;
  logic [WORD_BITS-1:0]                  peek_word;
  logic signed [WORD_BITS-1:0]           rd_word;
  logic signed [63:0]                    rd_ext;
  isrm_pkg::status_e                     status;
  logic [31:0]                           count_ext;
  logic [isrm_pkg::M_TDATA_W-1:0]        res_d, res_q;
  logic                                  res_valid_q;

  // depth 0 reads the top, same as depth 1
  assign depth_eff = (depth_pos == '0) ? isrm_pkg::DEPTH_W'(1) : depth_pos;
  assign peek_idx  = depth_eff - isrm_pkg::DEPTH_W'(1);

  always_comb begin
    peek_word = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (32'(peek_idx) == 32'(i)) begin
        peek_word = cell_word[i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    status  = isrm_pkg::ST_OK;
    rd_word = '1;
    case (cmd)
      isrm_pkg::CMD_PUSH: begin
        if (is_full_now) begin
          status = isrm_pkg::ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      isrm_pkg::CMD_POP: begin
        if (is_empty_now) begin
          status = isrm_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
          rd_word = cell_word[0];
        end
      end
      isrm_pkg::CMD_PEEK: begin
        if (is_empty_now) begin
          status = isrm_pkg::ST_EMPTY;
        end else if (32'(depth_eff) > 32'(count_q)) begin
          status = isrm_pkg::ST_NOTFOUND;
        end else begin
          rd_word = peek_word;
        end
      end
      isrm_pkg::CMD_REMOVE: begin
        if (is_empty_now) begin
          status = isrm_pkg::ST_EMPTY;
        end else if (!found) begin
          status = isrm_pkg::ST_NOTFOUND;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
        status = isrm_pkg::ST_OK;
      end
    endcase
  end

  assign rd_ext    = 64'(rd_word);
  assign count_ext = 32'(count_d);
  assign res_d     = {(count_d == '0),
                      count_ext[isrm_pkg::COUNT_W-1:0],
                      status,
                      rd_ext[isrm_pkg::DATA_W-1:0]};

  // --------------------------------------------------------------------------
  // Handshake and registers
  // --------------------------------------------------------------------------
  assign s_axis_tready = !res_valid_q || m_axis_tready;
  assign req_fire      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        count_q <= count_d;
      end
      if (s_axis_tready) begin
        res_valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = res_q;

endmodule

@@ tb/integer_stack_with_remove_tb.sv @@
// ----------------------------------------------------------------------------
// integer_stack_with_remove_tb
// Self-checking bench for the LIFO stack with peek and remove-by-value.
// A shadow stack predicts every result; commands go in on s_axis, results
// come back on m_axis and are checked field by field in arrival order.
// ----------------------------------------------------------------------------

// Shadow stack plus the queue of results it still owes.
class stack_scoreboard;

  typedef struct packed {
    logic [31:0]       data;
    isrm_pkg::status_e status;
    logic [4:0]        count;
    logic              is_empty;
  } stack_result_t;

  localparam int unsigned DEPTH = isrm_pkg::STACK_DEPTH_DEF;

  logic [31:0]   slot_word [DEPTH];  // slot 0 is the bottom
  int unsigned   fill;
  stack_result_t pending_results[$];
  int            errors;
  int            n_checked;
  int            cmd_seen [4];
  int            status_seen [4];
  int unsigned   max_fill;

  function new();
    fill      = 0;
    errors    = 0;
    n_checked = 0;
    max_fill  = 0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  // Apply one accepted request to the shadow stack, queue its result.
  function void note_request(isrm_pkg::cmd_e cmd, logic [31:0] value, logic [4:0] depth);
    stack_result_t r;
    int unsigned   d;
    int            hit_at;
    r.data   = '1;
    r.status = isrm_pkg::ST_OK;
    hit_at   = -1;
    case (cmd)
      isrm_pkg::CMD_PUSH: begin
        if (fill >= DEPTH) begin
          r.status = isrm_pkg::ST_FULL;
        end else begin
          slot_word[fill] = value;
          fill++;
        end
      end
      isrm_pkg::CMD_POP: begin
        if (fill == 0) begin
          r.status = isrm_pkg::ST_EMPTY;
        end else begin
          fill--;
          r.data = slot_word[fill];
        end
      end
      isrm_pkg::CMD_PEEK: begin
        d = (depth == 0) ? 1 : depth;  // depth 0 reads the top as well
        if (fill == 0) begin
          r.status = isrm_pkg::ST_EMPTY;
        end else if (d > fill) begin
          r.status = isrm_pkg::ST_NOTFOUND;
        end else begin
          r.data = slot_word[fill - d];
        end
      end
      default: begin
        if (fill == 0) begin
          r.status = isrm_pkg::ST_EMPTY;
        end else begin
          // topmost match wins
          for (int i = int'(fill) - 1; i >= 0; i--) begin
            if (hit_at < 0 && slot_word[i] == value) hit_at = i;
          end
          if (hit_at < 0) begin
            r.status = isrm_pkg::ST_NOTFOUND;
          end else begin
            for (int i = hit_at; i + 1 < int'(fill); i++) slot_word[i] = slot_word[i + 1];
            fill--;
          end
        end
      end
    endcase
    r.count    = fill[4:0];
    r.is_empty = (fill == 0);
    if (fill > max_fill) max_fill = fill;
    cmd_seen[cmd]++;
    status_seen[r.status]++;
    pending_results.push_back(r);
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("  mismatch #%0d on result %0d: %s got %h want %h",
             errors, n_checked, what, got, want);
    errors++;
  endtask

  // Compare one accepted result against the oldest expectation.
  task check_result(logic [isrm_pkg::M_TDATA_W-1:0] tdata);
    stack_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result, tdata[31:0]", tdata[31:0], '0);
    end else begin
      want = pending_results.pop_front();
      if (tdata[31:0] !== want.data) report_mismatch("data", tdata[31:0], want.data);
      if (tdata[33:32] !== want.status)
        report_mismatch("status", 32'(tdata[33:32]), 32'(want.status));
      if (tdata[38:34] !== want.count)
        report_mismatch("count", 32'(tdata[38:34]), 32'(want.count));
      if (tdata[39] !== want.is_empty)
        report_mismatch("is_empty", 32'(tdata[39]), 32'(want.is_empty));
    end
    n_checked++;
  endtask

endclass

module integer_stack_with_remove_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 600;   // per idling phase, three phases
  localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
  localparam int HOLD_AT      = 1400;  // result count that starts it

  logic                                 clk_i;
  logic                                 rst_ni = 1'b0;
  logic                                 s_axis_tvalid = 1'b0;
  logic                                 s_axis_tready;
  // [31:0] value, [36:32] depth_pos, [39:37] zero
  logic [isrm_pkg::S_TDATA_W-1:0]       s_axis_tdata = '0;
  // [1:0] cmd
  logic [isrm_pkg::CMD_W-1:0]           s_axis_tuser = '0;
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready = 1'b0;
  // [31:0] data, [33:32] status, [38:34] count, [39] is_empty
  logic [isrm_pkg::M_TDATA_W-1:0]       m_axis_tdata;

  stack_scoreboard sb = new();

  int tx_idle_pct = 17;
  int rx_idle_pct = 81;
  int cycle_count = 0;

  integer_stack_with_remove u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a lost or stuck result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL integer_stack_with_remove");
      $finish;
    end
  end

  // Result side: check on handshake, then pick tready for the next cycle.
  // Once, deep into the run, tready stays low for a long stretch so the
  // output register fills and s_axis_tready drops while requests wait.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (!hold_done && sb.n_checked >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Drive one request and wait for it to be taken; valid stays high
  // afterwards so back-to-back requests need no extra assignment.
  task automatic send_request(isrm_pkg::cmd_e cmd, logic [31:0] value, logic [4:0] depth);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, depth, value};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cmd, value, depth);
  endtask

  // Small pool so removes hit and duplicates pile up; extremes and full
  // 32-bit noise mixed in.
  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 32'($urandom_range(7));
    if (r < 65) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'hffff_ffff;
        default: return 32'h0;
      endcase
    end
    return $urandom;
  endfunction

  // Random traffic in bursts: fill-heavy, drain-heavy or balanced, so the
  // stack keeps swinging between empty and full.
  task automatic run_random(int n_items);
    int             burst_left;
    int             mode;
    int unsigned    r;
    isrm_pkg::cmd_e cmd;
    logic [31:0]    value;
    logic [4:0]     depth;
    burst_left = 0;
    mode = 0;
    for (int k = 0; k < n_items; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(60, 20);
        mode = $urandom_range(2);
      end
      burst_left--;
      r = $urandom_range(99);
      case (mode)
        0:       cmd = (r < 65) ? isrm_pkg::CMD_PUSH : (r < 75) ? isrm_pkg::CMD_POP :
                       (r < 90) ? isrm_pkg::CMD_PEEK : isrm_pkg::CMD_REMOVE;
        1:       cmd = (r < 15) ? isrm_pkg::CMD_PUSH : (r < 60) ? isrm_pkg::CMD_POP :
                       (r < 80) ? isrm_pkg::CMD_PEEK : isrm_pkg::CMD_REMOVE;
        default: cmd = isrm_pkg::cmd_e'(r % 4);
      endcase
      value = pick_word();
      if (cmd == isrm_pkg::CMD_REMOVE && sb.fill > 0 && $urandom_range(99) < 60)
        value = sb.slot_word[$urandom_range(sb.fill - 1)];
      if ($urandom_range(99) < 70) depth = 5'($urandom_range(sb.fill + 1));
      else                         depth = 5'($urandom_range(31));
      send_request(cmd, value, depth);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty cases, word extremes, peek at depth 0/1/bottom/beyond,
    // remove of the topmost duplicate, remove from the middle, no match.
    send_request(isrm_pkg::CMD_POP,    32'h0,         5'd0);
    send_request(isrm_pkg::CMD_PEEK,   32'h0,         5'd0);
    send_request(isrm_pkg::CMD_REMOVE, 32'd5,         5'd0);
    send_request(isrm_pkg::CMD_PUSH,   32'h7fff_ffff, 5'd0);
    send_request(isrm_pkg::CMD_PUSH,   32'h8000_0000, 5'd31);
    send_request(isrm_pkg::CMD_PUSH,   32'hffff_ffff, 5'd0);
    send_request(isrm_pkg::CMD_PUSH,   32'h0,         5'd0);
    send_request(isrm_pkg::CMD_PUSH,   32'h7fff_ffff, 5'd0);
    send_request(isrm_pkg::CMD_PEEK,   32'h0,         5'd0);
    send_request(isrm_pkg::CMD_PEEK,   32'h0,         5'd1);
    send_request(isrm_pkg::CMD_PEEK,   32'h0,         5'd5);
    send_request(isrm_pkg::CMD_PEEK,   32'h0,         5'd6);
    send_request(isrm_pkg::CMD_PEEK,   32'hffff_ffff, 5'd31);
    send_request(isrm_pkg::CMD_REMOVE, 32'h7fff_ffff, 5'd0);
    send_request(isrm_pkg::CMD_PEEK,   32'h0,         5'd1);
    send_request(isrm_pkg::CMD_REMOVE, 32'd12345,     5'd0);
    send_request(isrm_pkg::CMD_REMOVE, 32'h8000_0000, 5'd0);
    send_request(isrm_pkg::CMD_PEEK,   32'h0,         5'd3);
    send_request(isrm_pkg::CMD_POP,    32'h0,         5'd0);
    send_request(isrm_pkg::CMD_POP,    32'h0,         5'd0);
    send_request(isrm_pkg::CMD_POP,    32'h0,         5'd0);
    send_request(isrm_pkg::CMD_POP,    32'h0,         5'd0);

    run_random(RANDOM_ITEMS);
    tx_idle_pct = 81;
    rx_idle_pct = 17;
    run_random(RANDOM_ITEMS);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(RANDOM_ITEMS);
    s_axis_tvalid <= 1'b0;

    // drain, then a few cycles for any stray late result
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("Ran %0d requests (push %0d, pop %0d, peek %0d, remove %0d), max fill %0d.",
             sb.n_checked, sb.cmd_seen[isrm_pkg::CMD_PUSH],
             sb.cmd_seen[isrm_pkg::CMD_POP], sb.cmd_seen[isrm_pkg::CMD_PEEK],
             sb.cmd_seen[isrm_pkg::CMD_REMOVE], sb.max_fill);
    $display("Status seen: ok %0d, empty %0d, full %0d, not found %0d; %0d mismatches.",
             sb.status_seen[isrm_pkg::ST_OK], sb.status_seen[isrm_pkg::ST_EMPTY],
             sb.status_seen[isrm_pkg::ST_FULL], sb.status_seen[isrm_pkg::ST_NOTFOUND],
             sb.errors);
    if (sb.errors == 0) begin
      $display("PASS integer_stack_with_remove");
    end else begin
      $display("FAIL integer_stack_with_remove");
    end
    $finish;
  end

endmodule
